// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Every check samples on clk_i and is
// off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled clock edge.
`define GWBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The expression must never be true at a sampled clock edge.
`define GWBS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- hdl/gwbs_pkg.sv -----
package gwbs_pkg;

  // Fixed field widths.
  localparam int TIME_W    = 48;
  localparam int WIN_W     = 16;
  localparam int RET_W     = 32;
  localparam int OCNT_W    = 7;
  localparam int NUM_LANES = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // Weight table: GAUSS_STEPS must be a power of two.
  localparam int GAUSS_STEPS  = 64;
  localparam int IDX_W        = $clog2(GAUSS_STEPS);
  localparam int W_W          = 17;
  localparam int W_ONE        = 65536;
  localparam int ONE_SHIFT    = 16;
  localparam int TAYLOR_ORDER = 12;
  localparam logic [63:0] Q30_ONE   = 64'd1073741824;
  localparam logic [63:0] GAUSS_DEN = 64'(2 * GAUSS_STEPS * GAUSS_STEPS);

  // Millisecond thresholds turned into microseconds.
  localparam int US_PER_MS = 1000;
  localparam int WINUS_W   = 26;
  localparam int SPAN_W    = IDX_W + WIN_W;
  localparam int CEIL_W    = WIN_W + 1;
  localparam int THR_W     = 27;

  // Register reset values.
  localparam logic [WIN_W-1:0] WINDOW_RST = 16'd333;
  localparam logic [RET_W-1:0] RETAIN_RST = 32'd1000000;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETAIN = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DROP,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef logic [W_W-1:0] weight_t;
  typedef weight_t gauss_tab_t [GAUSS_STEPS];

  // exp(-n) in Q30 for n = 0..4.
  function automatic logic [63:0] exp_neg_int(logic [2:0] n);
    logic [63:0] r;
    case (n)
      3'd0:    r = 64'd1073741824;
      3'd1:    r = 64'd395007542;
      3'd2:    r = 64'd145315154;
      3'd3:    r = 64'd53458458;
      default: r = 64'd19666268;
    endcase
    return r;
  endfunction

  // Q16 Gaussian weights over the table index, sigma one third of the span.
  function automatic gauss_tab_t gauss_table();
    gauss_tab_t  tab;
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] ef;
    logic [63:0] v;
    for (int i = 0; i < GAUSS_STEPS; i++) begin
      x = ((64'd9 * 64'(i) * 64'(i)) << 30) / GAUSS_DEN;
      n = x >> 30;
      f = x & (Q30_ONE - 64'd1);
      if (n > 64'd4) begin
        n = 64'd4;
      end
      term = Q30_ONE;
      pos  = Q30_ONE;
      neg  = 64'd0;
      // Taylor series of exp(-f), alternating terms kept apart.
      for (int k = 1; k <= TAYLOR_ORDER; k++) begin
        term = ((term * f) >> 30) / 64'(k);
        if (k[0]) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      ef = (pos > neg) ? pos - neg : 64'd0;
      v = (ef * exp_neg_int(n[2:0])) >> 30;
      tab[i] = W_W'((v + 64'd8192) >> 14);
    end
    return tab;
  endfunction

endpackage

// ----- hdl/gwbs_if.sv -----
// Observation channel.
interface gwbs_obs_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic [gwbs_pkg::TIME_W-1:0]  timestamp_us;
  logic                         has_box;
  logic signed [COORD_BITS-1:0] box_x0;
  logic signed [COORD_BITS-1:0] box_x1;
  logic signed [COORD_BITS-1:0] box_y0;
  logic signed [COORD_BITS-1:0] box_y1;
  logic signed [COORD_BITS-1:0] box_z0;
  logic signed [COORD_BITS-1:0] box_z1;

  modport source (
    output valid, timestamp_us, has_box, box_x0, box_x1, box_y0, box_y1, box_z0, box_z1,
    input  ready
  );
  modport sink (
    input  valid, timestamp_us, has_box, box_x0, box_x1, box_y0, box_y1, box_z0, box_z1,
    output ready
  );
endinterface

// Smoothed result channel.
interface gwbs_mean_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] mean_x0;
  logic signed [COORD_BITS-1:0] mean_x1;
  logic signed [COORD_BITS-1:0] mean_y0;
  logic signed [COORD_BITS-1:0] mean_y1;
  logic signed [COORD_BITS-1:0] mean_z0;
  logic signed [COORD_BITS-1:0] mean_z1;
  logic [gwbs_pkg::OCNT_W-1:0]  used_count;
  logic [gwbs_pkg::OCNT_W-1:0]  history_count;

  modport source (
    output valid, mean_x0, mean_x1, mean_y0, mean_y1, mean_z0, mean_z1, used_count,
           history_count,
    input  ready
  );
  modport sink (
    input  valid, mean_x0, mean_x1, mean_y0, mean_y1, mean_z0, mean_z1, used_count,
           history_count,
    output ready
  );
endinterface

// ----- hdl/gaussian_weighted_box_smoother.sv -----
// One item at a time: the history walk (one slot a cycle through the rotating row of
// cells) and the shared bit-serial divider set the time that an item takes; a new item
// is taken while the previous result still waits in the output register.
// Reset clears the registers to 333 ms / 1000000 us and empties the history at once.
`include "assert_macros.svh"

module gaussian_weighted_box_smoother #(
  parameter int HISTORY_DEPTH = 64,
  parameter int COORD_BITS    = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gwbs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gwbs_pkg::CFG_W-1:0]         cfg_data_i,
  gwbs_obs_if.sink                           obs_i,
  gwbs_mean_if.source                        mean_o
);

  localparam int LANES  = gwbs_pkg::NUM_LANES;
  localparam int TIME_W = gwbs_pkg::TIME_W;
  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int HC_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int BOX_W  = LANES * COORD_BITS;
  localparam int ENT_W  = TIME_W + 1 + BOX_W;
  localparam int WS_W   = gwbs_pkg::W_W + HC_W;
  localparam int ACC_W  = COORD_BITS + WS_W;
  localparam int PROD_W = COORD_BITS + gwbs_pkg::W_W;
  localparam int LN_W   = $clog2(LANES);

  gwbs_pkg::state_e state_q, state_d;

  // Configuration.
  logic [gwbs_pkg::WIN_W-1:0] win_q;
  logic [gwbs_pkg::RET_W-1:0] ret_q;
  logic [gwbs_pkg::WIN_W-1:0] win_eff;
  logic [gwbs_pkg::WINUS_W-1:0] win_us;

  // Current item.
  logic [TIME_W-1:0] now_q;
  logic              hb_q;
  logic [BOX_W-1:0]  cur_q;
  logic [BOX_W-1:0]  in_box;

  // Walk control.
  logic [HC_W-1:0] cnt_q, cnt_d;
  logic [HC_W-1:0] step_q, step_d;
  logic [HC_W-1:0] ev_q, ev_d;
  logic [HC_W-1:0] drop_q, drop_d;
  logic [HC_W:0]   used_q, used_d;
  logic            evict_q, evict_d;
  logic [LN_W-1:0] lane_q, lane_d;
  logic            div_go_q, div_go_d;
  logic [HC_W-1:0] keep;
  logic            full;

  logic take_in;
  logic shift_en;
  logic load_en;
  logic push;
  logic out_load;

  // History row.
  gwbs_pkg::cell_ctl_t ctl [HISTORY_DEPTH];
  logic [ENT_W-1:0]    ent [HISTORY_DEPTH];
  logic [ENT_W-1:0]    new_ent;
  logic [TIME_W-1:0]   h_time;
  logic                h_vb;
  logic [BOX_W-1:0]    h_box;
  logic [TIME_W-1:0]   age;
  logic                in_list;
  logic                ev_cond;
  logic                in_win;

  // Accumulation and division.
  logic                     wp_vld;
  logic                     wp_busy;
  logic [gwbs_pkg::W_W-1:0] wp_w;
  logic [LANES*PROD_W-1:0]  wp_prod;
  logic [WS_W-1:0]          wsum_q;
  logic signed [ACC_W-1:0]  sum_q [LANES];
  logic signed [ACC_W-1:0]  sel;
  logic                     sel_neg;
  logic [ACC_W-1:0]         mag;
  logic [ACC_W-1:0]         num;
  logic                     div_busy;
  logic                     div_done;
  logic [COORD_BITS-1:0]    div_q;
  logic [COORD_BITS-1:0]    res_q [LANES];

  // Output register.
  logic                        oval_q;
  logic [COORD_BITS-1:0]       mean_q [LANES];
  logic [gwbs_pkg::OCNT_W-1:0] used_o_q;
  logic [gwbs_pkg::OCNT_W-1:0] hist_o_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= gwbs_pkg::WINDOW_RST;
      ret_q <= gwbs_pkg::RETAIN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gwbs_pkg::CFG_WINDOW) begin
        win_q <= cfg_data_i[gwbs_pkg::WIN_W-1:0];
      end
      if (cfg_idx_i == gwbs_pkg::CFG_RETAIN) begin
        ret_q <= cfg_data_i[gwbs_pkg::RET_W-1:0];
      end
    end
  end

  assign win_eff = (win_q == '0) ? gwbs_pkg::WIN_W'(1) : win_q;
  assign win_us  = gwbs_pkg::WINUS_W'(win_eff) * gwbs_pkg::WINUS_W'(gwbs_pkg::US_PER_MS);

  assign in_box = {obs_i.box_z1, obs_i.box_z0, obs_i.box_y1, obs_i.box_y0,
                   obs_i.box_x1, obs_i.box_x0};
  assign obs_i.ready = (state_q == gwbs_pkg::ST_IDLE);
  assign new_ent = {now_q, hb_q, cur_q};

  // Row of history cells; slot zero is the head that the walk inspects.
  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
    always_comb begin
      ctl[k].shift = shift_en;
      ctl[k].load  = load_en && (cnt_q[AW-1:0] == AW'(k));
    end
    gwbs_cell #(
      .ENT_W (ENT_W)
    ) u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl[k]),
      .nbr_i (ent[(k + 1) % HISTORY_DEPTH]),
      .new_i (new_ent),
      .ent_o (ent[k])
    );
  end

  // Head entry tests.
  always_comb begin
    h_time  = ent[0][ENT_W-1 -: TIME_W];
    h_vb    = ent[0][BOX_W];
    h_box   = ent[0][BOX_W-1:0];
    age     = (h_time > now_q) ? h_time - now_q : now_q - h_time;
    in_list = (step_q < cnt_q);
    ev_cond = (({1'b0, h_time} + (TIME_W+1)'(ret_q)) < {1'b0, now_q});
    in_win  = (({1'b0, h_time} + (TIME_W+1)'(win_us)) > {1'b0, now_q});
  end

  // Sequencer: walk, drop, append, drain, divide, hand over.
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    evict_d  = evict_q;
    ev_d     = ev_q;
    used_d   = used_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    lane_d   = lane_q;
    div_go_d = 1'b0;
    take_in  = 1'b0;
    shift_en = 1'b0;
    load_en  = 1'b0;
    push     = 1'b0;
    out_load = 1'b0;
    keep     = '0;
    full     = 1'b0;
    unique case (state_q)
      gwbs_pkg::ST_IDLE: begin
        if (obs_i.valid) begin
          take_in = 1'b1;
          step_d  = '0;
          evict_d = 1'b1;
          ev_d    = '0;
          used_d  = (HC_W+1)'(1);
          state_d = gwbs_pkg::ST_WALK;
        end
      end
      gwbs_pkg::ST_WALK: begin
        shift_en = 1'b1;
        step_d   = step_q + HC_W'(1);
        if (in_list) begin
          if (evict_q && ev_cond) begin
            ev_d = ev_q + HC_W'(1);
          end else begin
            evict_d = 1'b0;
            if (h_vb && in_win) begin
              push   = 1'b1;
              used_d = used_q + (HC_W+1)'(1);
            end
          end
        end
        keep = cnt_q - ev_d;
        full = (keep == HC_W'(HISTORY_DEPTH));
        if (step_q == HC_W'(HISTORY_DEPTH - 1)) begin
          drop_d  = ev_d + HC_W'(full);
          cnt_d   = keep - HC_W'(full);
          state_d = gwbs_pkg::ST_DROP;
        end
      end
      gwbs_pkg::ST_DROP: begin
        if (drop_q != '0) begin
          shift_en = 1'b1;
          drop_d   = drop_q - HC_W'(1);
        end else begin
          load_en = 1'b1;
          cnt_d   = cnt_q + HC_W'(1);
          state_d = gwbs_pkg::ST_DRAIN;
        end
      end
      gwbs_pkg::ST_DRAIN: begin
        if (!wp_busy) begin
          lane_d   = '0;
          div_go_d = 1'b1;
          state_d  = gwbs_pkg::ST_DIV;
        end
      end
      gwbs_pkg::ST_DIV: begin
        if (div_done) begin
          if (lane_q == LN_W'(LANES - 1)) begin
            state_d = gwbs_pkg::ST_OUT;
          end else begin
            lane_d   = lane_q + LN_W'(1);
            div_go_d = 1'b1;
          end
        end
      end
      gwbs_pkg::ST_OUT: begin
        if (!oval_q || mean_o.ready) begin
          out_load = 1'b1;
          state_d  = gwbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gwbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gwbs_pkg::ST_IDLE;
      step_q   <= '0;
      evict_q  <= 1'b0;
      ev_q     <= '0;
      used_q   <= '0;
      cnt_q    <= '0;
      drop_q   <= '0;
      lane_q   <= '0;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      evict_q  <= evict_d;
      ev_q     <= ev_d;
      used_q   <= used_d;
      cnt_q    <= cnt_d;
      drop_q   <= drop_d;
      lane_q   <= lane_d;
      div_go_q <= div_go_d;
    end
  end

  // Capture the accepted observation.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      now_q <= obs_i.timestamp_us;
      hb_q  <= obs_i.has_box;
      cur_q <= in_box;
    end
  end

  gwbs_weight #(
    .COORD_BITS (COORD_BITS)
  ) u_weight (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (push),
    .age_i  (age),
    .win_i  (win_eff),
    .box_i  (h_box),
    .vld_o  (wp_vld),
    .w_o    (wp_w),
    .prod_o (wp_prod),
    .busy_o (wp_busy)
  );

  // Weighted sums; the current box enters with the full weight.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      wsum_q <= WS_W'(gwbs_pkg::W_ONE);
      for (int j = 0; j < LANES; j++) begin
        sum_q[j] <= ACC_W'($signed(in_box[j*COORD_BITS +: COORD_BITS])) <<< gwbs_pkg::ONE_SHIFT;
      end
    end else if (wp_vld) begin
      wsum_q <= wsum_q + WS_W'(wp_w);
      for (int j = 0; j < LANES; j++) begin
        sum_q[j] <= sum_q[j] + ACC_W'($signed(wp_prod[j*PROD_W +: PROD_W]));
      end
    end
  end

  // Rounded magnitude division, ties away from zero.
  always_comb begin
    sel     = sum_q[lane_q];
    sel_neg = sel[ACC_W-1];
    mag     = sel_neg ? ACC_W'(-sel) : ACC_W'(sel);
    num     = mag + ACC_W'(wsum_q >> 1);
  end

  gwbs_div #(
    .DEN_W (WS_W),
    .Q_W   (COORD_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (num),
    .den_i   (wsum_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      res_q[lane_q] <= sel_neg ? COORD_BITS'(-div_q) : div_q;
    end
  end

  // Output register; a result waits here while the next item is worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (out_load) begin
      oval_q <= 1'b1;
    end else if (mean_o.ready) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mean_q   <= res_q;
      used_o_q <= gwbs_pkg::OCNT_W'(used_q);
      hist_o_q <= gwbs_pkg::OCNT_W'(cnt_q);
    end
  end

  assign mean_o.valid         = oval_q;
  assign mean_o.mean_x0       = mean_q[0];
  assign mean_o.mean_x1       = mean_q[1];
  assign mean_o.mean_y0       = mean_q[2];
  assign mean_o.mean_y1       = mean_q[3];
  assign mean_o.mean_z0       = mean_q[4];
  assign mean_o.mean_z1       = mean_q[5];
  assign mean_o.used_count    = used_o_q;
  assign mean_o.history_count = hist_o_q;

  // Checks.
  `GWBS_ASSERT(a_cnt_bound, cnt_q <= HC_W'(HISTORY_DEPTH), "history count above depth")
  `GWBS_ASSERT(a_div_start_idle, div_go_q |-> !div_busy, "divider started while busy")
  `GWBS_ASSERT_NEVER(a_div_pipe_empty, (state_q == gwbs_pkg::ST_DIV) && wp_busy, "weight pipeline busy during division")
  `GWBS_ASSERT(a_used_bound, (state_q == gwbs_pkg::ST_OUT) |-> (used_q <= ({1'b0, cnt_q} + (HC_W+1)'(1))), "more boxes used than held")

endmodule

// ----- hdl/gwbs_cell.sv -----
// One history slot. The row of slots rotates toward slot zero, and any slot
// can take the new observation.
module gwbs_cell #(
  parameter int ENT_W = 193
) (
  input  logic                clk_i,
  input  gwbs_pkg::cell_ctl_t ctl_i,
  input  logic [ENT_W-1:0]    nbr_i,
  input  logic [ENT_W-1:0]    new_i,
  output logic [ENT_W-1:0]    ent_o
);

  logic [ENT_W-1:0] ent_q;
  logic [ENT_W-1:0] ent_d;

  // A load wins over a shift; otherwise the slot holds.
  always_comb begin
    priority if (ctl_i.load) begin
      ent_d = new_i;
    end else if (ctl_i.shift) begin
      ent_d = nbr_i;
    end else begin
      ent_d = ent_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ----- hdl/gwbs_weight.sv -----
// Weight pipeline: one entry per cycle. A binary search over the millisecond
// thresholds finds the table index, then the weight scales the six coordinates.
module gwbs_weight #(
  parameter int COORD_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  logic [gwbs_pkg::TIME_W-1:0]         age_i,
  input  logic [gwbs_pkg::WIN_W-1:0]          win_i,
  input  logic [gwbs_pkg::NUM_LANES*COORD_BITS-1:0] box_i,
  output logic                                vld_o,
  output logic [gwbs_pkg::W_W-1:0]            w_o,
  output logic [gwbs_pkg::NUM_LANES*(COORD_BITS+gwbs_pkg::W_W)-1:0] prod_o,
  output logic                                busy_o
);

  localparam int LANES  = gwbs_pkg::NUM_LANES;
  localparam int IDX_W  = gwbs_pkg::IDX_W;
  localparam int BOX_W  = LANES * COORD_BITS;
  localparam int PROD_W = COORD_BITS + gwbs_pkg::W_W;
  localparam int NST    = IDX_W + 1;
  localparam gwbs_pkg::gauss_tab_t GAUSS_TAB = gwbs_pkg::gauss_table();

  logic                        vld_q [NST];
  logic [gwbs_pkg::TIME_W-1:0] age_q [NST];
  logic [IDX_W-1:0]            idx_q [NST];
  logic [BOX_W-1:0]            box_q [NST];

  logic                   vo_q;
  logic [gwbs_pkg::W_W-1:0] w_q;
  logic [LANES*PROD_W-1:0] prod_q;
  logic [LANES*PROD_W-1:0] prod_d;
  logic [gwbs_pkg::W_W-1:0] tab_w;

  // Entry stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q[0] <= age_i;
    idx_q[0] <= '0;
    box_q[0] <= box_i;
  end

  // One index bit per stage, most significant first.
  for (genvar b = 0; b < IDX_W; b++) begin : g_search
    logic [IDX_W-1:0]           cand;
    logic [gwbs_pkg::SPAN_W-1:0] span;
    logic [gwbs_pkg::CEIL_W-1:0] ceil_v;
    logic [gwbs_pkg::THR_W-1:0]  thr;

    always_comb begin
      cand   = idx_q[b] | (IDX_W'(1) << (IDX_W - 1 - b));
      span   = gwbs_pkg::SPAN_W'(cand) * gwbs_pkg::SPAN_W'(win_i);
      ceil_v = gwbs_pkg::CEIL_W'(span >> IDX_W) + gwbs_pkg::CEIL_W'(|span[IDX_W-1:0]);
      thr    = gwbs_pkg::THR_W'(ceil_v) * gwbs_pkg::THR_W'(gwbs_pkg::US_PER_MS);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[b+1] <= 1'b0;
      end else begin
        vld_q[b+1] <= vld_q[b];
      end
    end

    always_ff @(posedge clk_i) begin
      age_q[b+1] <= age_q[b];
      box_q[b+1] <= box_q[b];
      idx_q[b+1] <= (age_q[b] >= gwbs_pkg::TIME_W'(thr)) ? cand : idx_q[b];
    end
  end

  // Weight lookup and the six products.
  assign tab_w = GAUSS_TAB[idx_q[IDX_W]];

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic signed [PROD_W-1:0] wa;
    logic signed [PROD_W-1:0] ca;
    always_comb begin
      wa = PROD_W'(tab_w);
      ca = PROD_W'($signed(box_q[IDX_W][j*COORD_BITS +: COORD_BITS]));
      prod_d[j*PROD_W +: PROD_W] = wa * ca;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vld_q[IDX_W];
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= tab_w;
    prod_q <= prod_d;
  end

  // Anything still in flight.
  always_comb begin
    busy_o = vo_q;
    for (int s = 0; s < NST; s++) begin
      busy_o = busy_o | vld_q[s];
    end
  end

  assign vld_o  = vo_q;
  assign w_o    = w_q;
  assign prod_o = prod_q;

endmodule

// ----- hdl/gwbs_div.sv -----
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in Q_W bits.
module gwbs_div #(
  parameter int DEN_W = 24,
  parameter int Q_W   = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DEN_W+Q_W-1:0] num_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [Q_W-1:0]       q_o
);

  localparam int CNT_W = $clog2(Q_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic [Q_W-1:0]   lo_q;
  logic [Q_W-1:0]   q_q;
  logic [DEN_W:0]   r2;
  logic             ge;

  // Trial subtraction of the next remainder.
  always_comb begin
    r2 = {rem_q[DEN_W-1:0], lo_q[Q_W-1]};
    ge = (r2 >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(Q_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[DEN_W+Q_W-1:Q_W]};
      lo_q  <= num_i[Q_W-1:0];
      den_q <= den_i;
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? r2 - {1'b0, den_q} : r2;
      lo_q  <= lo_q << 1;
      q_q   <= {q_q[Q_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign q_o    = q_q;

endmodule
